// File: sv/dih_pkg.sv
// dih_pkg: shared types and constants for the directional input history recogniser.
// No dependencies; used by every module of the block and by its checker.
`timescale 1ns / 1ps

package dih_pkg;

   localparam logic [3:0] NEUTRAL_DIR  = 4'd5;
   localparam logic [7:0] AGE_MAX      = 8'd255;
   localparam int         TAP_SPAN     = 14;
   localparam int         MOTION_FRESH = 3;

   localparam logic [1:0] KIND_UPDATE = 2'd0;
   localparam logic [1:0] KIND_MOTION = 2'd1;
   localparam logic [1:0] KIND_TAP    = 2'd2;
   localparam logic [1:0] KIND_BUFFER = 2'd3;

   // control broadcast along the history chain
   typedef struct packed {
      logic push;   // frame update: shift towards older ages
      logic rot;    // query walk: rotate towards cell 0
   } cell_ctl_type;

endpackage

// File: sv/dih_cell.sv
// dih_cell: one entry of the direction history chain.
// Depends on dih_pkg (cell_ctl_type, NEUTRAL_DIR).
`timescale 1ns / 1ps

module dih_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  dih_pkg::cell_ctl_type ctl,
   input  logic [3:0]            younger_dir,
   input  logic [3:0]            older_dir,
   output logic [3:0]            dir
);

   logic [3:0] dir_ff;
   logic [3:0] dir_in;

   always_comb begin
      dir_in = dir_ff;
      if (ctl.push) begin
         dir_in = younger_dir;
      end else if (ctl.rot) begin
         dir_in = older_dir;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= dih_pkg::NEUTRAL_DIR;
      end else begin
         dir_ff <= dir_in;
      end
   end

   assign dir = dir_ff;

endmodule

// File: sv/dih_match.sv
// dih_match: motion and double tap matchers, fed one history entry per cycle.
// Depends on dih_pkg (constants).
`timescale 1ns / 1ps

module dih_match #(
   parameter int AW                = 5,
   parameter int MAX_MOTION_DIGITS = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  logic          load_motion,
   input  logic [31:0]   motion_digits,
   input  logic [3:0]    motion_length,
   input  logic [7:0]    window,
   input  logic [3:0]    tap_dir,
   input  logic          step,
   input  logic [AW-1:0] age,
   input  logic [3:0]    dir,
   output logic          hit
);

   localparam int CW = (AW > 8) ? AW : 8;

   localparam logic [1:0] TAP_HOLD  = 2'd0;
   localparam logic [1:0] TAP_GAP   = 2'd1;
   localparam logic [1:0] TAP_AGAIN = 2'd2;

   logic        motion_ff, motion_in;
   logic [31:0] digits_ff, digits_in;
   logic [2:0]  want_ff, want_in;
   logic [2:0]  last_ff, last_in;
   logic [7:0]  window_ff, window_in;
   logic [3:0]  tap_ff, tap_in;
   logic [1:0]  stage_ff, stage_in;
   logic        done_ff, done_in;
   logic        hit_ff, hit_in;
   logic [3:0]  len_clamp;
   logic [3:0]  need;

   assign need = digits_ff[{want_ff, 2'b00} +: 4];

   always_comb begin
      motion_in = motion_ff;
      digits_in = digits_ff;
      want_in   = want_ff;
      last_in   = last_ff;
      window_in = window_ff;
      tap_in    = tap_ff;
      stage_in  = stage_ff;
      done_in   = done_ff;
      hit_in    = hit_ff;
      len_clamp = (motion_length > 4'(MAX_MOTION_DIGITS)) ? 4'(MAX_MOTION_DIGITS)
                                                          : motion_length;
      if (load) begin
         motion_in = load_motion;
         digits_in = motion_digits;
         want_in   = 3'(len_clamp - 4'd1);
         last_in   = 3'(len_clamp - 4'd1);
         window_in = window;
         tap_in    = tap_dir;
         stage_in  = TAP_HOLD;
         hit_in    = 1'b0;
         done_in   = load_motion && (motion_length == 4'd0);
      end else if (step && !done_ff) begin
         if (motion_ff) begin
            if (CW'(age) >= CW'(window_ff)) begin
               done_in = 1'b1;
            end else if (dir == need) begin
               if (want_ff == 3'd0) begin
                  done_in = 1'b1;
                  hit_in  = 1'b1;
               end else begin
                  want_in = want_ff - 3'd1;
               end
            end else if (want_ff == last_ff && age > AW'(dih_pkg::MOTION_FRESH)) begin
               done_in = 1'b1;
            end
         end else begin
            if (age >= AW'(dih_pkg::TAP_SPAN)) begin
               done_in = 1'b1;
            end else begin
               case (stage_ff)
                  TAP_HOLD: begin
                     if (age == '0 && dir != tap_ff) begin
                        done_in = 1'b1;
                     end else if (dir != tap_ff) begin
                        // leaving the first tap: judge this entry as a gap entry
                        if (dir == dih_pkg::NEUTRAL_DIR) begin
                           stage_in = TAP_GAP;
                        end else begin
                           done_in = 1'b1;
                        end
                     end
                  end
                  TAP_GAP: begin
                     if (dir == tap_ff) begin
                        stage_in = TAP_AGAIN;
                     end else if (dir != dih_pkg::NEUTRAL_DIR) begin
                        done_in = 1'b1;
                     end
                  end
                  TAP_AGAIN: begin
                     if (dir != tap_ff) begin
                        done_in = 1'b1;
                        hit_in  = (age > AW'(2));
                     end
                  end
                  default: begin
                     done_in = 1'b1;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= 1'b1;
         hit_ff   <= 1'b0;
         stage_ff <= TAP_HOLD;
      end else begin
         done_ff  <= done_in;
         hit_ff   <= hit_in;
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      motion_ff <= motion_in;
      digits_ff <= digits_in;
      want_ff   <= want_in;
      last_ff   <= last_in;
      window_ff <= window_in;
      tap_ff    <= tap_in;
   end

   assign hit = hit_ff;

endmodule

// File: sv/directional_input_history_recognizer_top.sv
// directional_input_history_recognizer_top: pad decode, press ages, history chain, query walk.
// Depends on dih_pkg, dih_cell and dih_match.
// Update and button buffer items give their result in the cycle after acceptance;
// motion and double tap items walk the whole chain and register their result at its end.
// Throughput: one update or buffer item per cycle while no query walks; a query holds busy
// while the chain rotates one entry past cell 0 per cycle, once round the whole chain.
// Reset (synchronous) sets the history to neutral and all press ages to 255; results
// are strobed for one cycle and cannot be stalled.
`timescale 1ns / 1ps

module directional_input_history_recognizer_top #(
   parameter int HISTORY_DEPTH     = 32,
   parameter int MAX_MOTION_DIGITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_raw,
   input  logic        req_facing_right,
   input  logic [31:0] req_motion_digits,
   input  logic [3:0]  req_motion_length,
   input  logic [7:0]  req_window,
   input  logic [3:0]  req_tap_dir,
   input  logic [3:0]  req_button_mask,
   input  logic [7:0]  req_frames,
   output logic        rsp_valid,
   output logic [3:0]  rsp_direction,
   output logic [3:0]  rsp_buttons_held,
   output logic [3:0]  rsp_buttons_pressed,
   output logic        rsp_query_hit
);

   localparam int AW = $clog2(HISTORY_DEPTH);

   // ---- control state ----
   logic          walk_ff, walk_in;
   logic [AW-1:0] step_ff, step_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          from_walk_ff, from_walk_in;
   logic          buf_hit_ff, buf_hit_in;

   // ---- architectural state outside the chain ----
   logic [3:0] cur_dir_ff, cur_dir_in;
   logic [3:0] held_ff, held_in;
   logic [3:0] pressed_ff, pressed_in;
   logic [7:0] age_ff [4];
   logic [7:0] age_in [4];

   logic       accept;
   logic       last_step;
   logic [3:0] new_dir;
   logic [1:0] col;
   logic [3:0] row_base;
   logic [3:0] btn;

   dih_pkg::cell_ctl_type cell_ctl;
   logic [3:0] chain_dir [HISTORY_DEPTH];

   assign accept    = start && !walk_ff;
   assign last_step = (step_ff == AW'(HISTORY_DEPTH - 1));
   assign btn       = req_raw[7:4];

   // pad decode: down beats up, right beats left, mirrored when facing left
   always_comb begin
      col = 2'd1;
      if (req_raw[2]) begin
         col = 2'd0;
      end
      if (req_raw[3]) begin
         col = 2'd2;
      end
      if (!req_facing_right) begin
         col = 2'd2 - col;
      end
      row_base = 4'd4;
      if (req_raw[0]) begin
         row_base = 4'd7;
      end
      if (req_raw[1]) begin
         row_base = 4'd1;
      end
      new_dir = row_base + {2'b00, col};
   end

   assign cell_ctl.push = accept && (req_kind == dih_pkg::KIND_UPDATE);
   assign cell_ctl.rot  = walk_ff;

   // ---- history chain: cell i holds the entry of age i ----
   // A full walk rotates HISTORY_DEPTH times, so the chain is back in place at the end.
   for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_chain
      logic [3:0] younger;
      logic [3:0] older;
      if (i == 0) begin : g_first
         assign younger = new_dir;
      end else begin : g_mid
         assign younger = chain_dir[i-1];
      end
      if (i == HISTORY_DEPTH - 1) begin : g_last
         assign older = chain_dir[0];
      end else begin : g_inner
         assign older = chain_dir[i+1];
      end
      dih_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (cell_ctl),
         .younger_dir (younger),
         .older_dir   (older),
         .dir         (chain_dir[i])
      );
   end

   // ---- matcher sees cell 0, i.e. the entry of age step_ff ----
   logic match_hit;

   dih_match #(
      .AW                (AW),
      .MAX_MOTION_DIGITS (MAX_MOTION_DIGITS)
   ) u_match (
      .clock         (clock),
      .reset         (reset),
      .load          (accept && (req_kind == dih_pkg::KIND_MOTION ||
                                 req_kind == dih_pkg::KIND_TAP)),
      .load_motion   (req_kind == dih_pkg::KIND_MOTION),
      .motion_digits (req_motion_digits),
      .motion_length (req_motion_length),
      .window        (req_window),
      .tap_dir       (req_tap_dir),
      .step          (walk_ff),
      .age           (step_ff),
      .dir           (chain_dir[0]),
      .hit           (match_hit)
   );

   // ---- sequencing and frame state ----
   always_comb begin
      walk_in      = walk_ff;
      step_in      = step_ff;
      rsp_valid_in = 1'b0;
      from_walk_in = from_walk_ff;
      buf_hit_in   = buf_hit_ff;
      cur_dir_in   = cur_dir_ff;
      held_in      = held_ff;
      pressed_in   = pressed_ff;
      for (int b = 0; b < 4; b++) begin
         age_in[b] = age_ff[b];
      end

      if (walk_ff) begin
         step_in = step_ff + AW'(1);
         if (last_step) begin
            walk_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end
      end else if (start) begin
         case (req_kind)
            dih_pkg::KIND_UPDATE: begin
               rsp_valid_in = 1'b1;
               from_walk_in = 1'b0;
               buf_hit_in   = 1'b0;
               cur_dir_in   = new_dir;
               pressed_in   = btn & ~held_ff;
               held_in      = btn;
               for (int b = 0; b < 4; b++) begin
                  if (btn[b] && !held_ff[b]) begin
                     age_in[b] = 8'd0;
                  end else if (age_ff[b] != dih_pkg::AGE_MAX) begin
                     age_in[b] = age_ff[b] + 8'd1;
                  end
               end
            end
            dih_pkg::KIND_MOTION, dih_pkg::KIND_TAP: begin
               walk_in      = 1'b1;
               step_in      = '0;
               from_walk_in = 1'b1;
            end
            dih_pkg::KIND_BUFFER: begin
               rsp_valid_in = 1'b1;
               from_walk_in = 1'b0;
               buf_hit_in   = 1'b0;
               for (int b = 0; b < 4; b++) begin
                  if (req_button_mask[b] && age_ff[b] <= req_frames) begin
                     buf_hit_in = 1'b1;
                  end
               end
            end
            default: begin
               rsp_valid_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         from_walk_ff <= 1'b0;
         buf_hit_ff   <= 1'b0;
         cur_dir_ff   <= dih_pkg::NEUTRAL_DIR;
         held_ff      <= 4'd0;
         pressed_ff   <= 4'd0;
         for (int b = 0; b < 4; b++) begin
            age_ff[b] <= dih_pkg::AGE_MAX;
         end
      end else begin
         walk_ff      <= walk_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         from_walk_ff <= from_walk_in;
         buf_hit_ff   <= buf_hit_in;
         cur_dir_ff   <= cur_dir_in;
         held_ff      <= held_in;
         pressed_ff   <= pressed_in;
         for (int b = 0; b < 4; b++) begin
            age_ff[b] <= age_in[b];
         end
      end
   end

   // ---- result port ----
   assign busy                = walk_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_direction       = cur_dir_ff;
   assign rsp_buttons_held    = held_ff;
   assign rsp_buttons_pressed = pressed_ff;
   assign rsp_query_hit       = from_walk_ff ? match_hit : buf_hit_ff;

endmodule

// File: sv/dih_checker.sv
// dih_checker: port-level assertions for the recogniser, bound to the top level.
// Depends on dih_pkg (item kind codes) and directional_input_history_recognizer_top.
`timescale 1ns / 1ps

module dih_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_kind,
   input logic        rsp_valid,
   input logic [3:0]  rsp_buttons_held,
   input logic [3:0]  rsp_buttons_pressed,
   input logic        rsp_query_hit
);

   logic acc;
   assign acc = start && !busy;

   a_update_result: assert property (@(posedge clock) disable iff (reset)
      acc && req_kind == dih_pkg::KIND_UPDATE |=> rsp_valid && !rsp_query_hit && !busy)
      else $error("update item gave no result or a hit");

   a_buffer_result: assert property (@(posedge clock) disable iff (reset)
      acc && req_kind == dih_pkg::KIND_BUFFER |=> rsp_valid && !busy)
      else $error("buffer query gave no result in one cycle");

   a_walk_busy: assert property (@(posedge clock) disable iff (reset)
      acc && (req_kind == dih_pkg::KIND_MOTION || req_kind == dih_pkg::KIND_TAP)
      |=> busy && !rsp_valid)
      else $error("history query did not hold busy");

   a_walk_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("walk ended without a result");

   a_pressed_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_buttons_pressed & ~rsp_buttons_held) == 4'd0)
      else $error("pressed button not held");

endmodule

bind directional_input_history_recognizer_top dih_checker u_dih_checker (.*);
